// File: rtl/crf_pkg.sv
package crf_pkg;

  localparam int ENTRIES   = 16;
  localparam int BUF_BYTES = 256;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int POS_W     = $clog2(BUF_BYTES);
  localparam int LEN_W     = 9;
  localparam int BUF_W     = IDX_W + 1;
  localparam int ADDR_W    = BUF_W + POS_W;
  localparam int MEM_DEPTH = 2 * ENTRIES * BUF_BYTES;

  localparam logic [3:0] ISO_FF       = 4'h1;
  localparam logic [3:0] ISO_CF       = 4'h2;
  localparam logic [7:0] ISO_CF_START = 8'h20;
  localparam logic [7:0] ISO_CF_TOP   = 8'h2F;
  localparam logic [7:0] FLAG_NEW     = 8'h01;
  localparam logic [3:0] MAX_FLEN     = 4'd8;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_FRAME = 3'd2,
    CMD_LOCK  = 3'd3,
    CMD_DUMP  = 3'd4,
    CMD_TICK  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    RS_OK      = 3'd0,
    RS_NO_ID   = 3'd1,
    RS_INVALID = 3'd2,
    RS_EXISTS  = 3'd3,
    RS_NO_ROOM = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_CUSTOM = 2'd1,
    MODE_ISOTP  = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_WR,
    ST_FIN,
    ST_RA,
    ST_RB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] element_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [1:0]  msg_mode;
    logic [2:0]  seq_position;
    logic [7:0]  seq_start;
    logic [8:0]  expected_len;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] time_stamp;
    logic [7:0]  flags;
    logic [8:0]  msg_length;
    logic [63:0] data_word;
    logic        last;
  } out_t;

  typedef struct packed {
    cmd_t        op;
    logic [31:0] id;
    logic [3:0]  flen;
    logic [63:0] data;
    mode_t       mode;
    logic [2:0]  spos;
    logic [7:0]  sstart;
    logic [8:0]  xlen;
  } item_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] spos;
    logic [7:0] sstart;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             store;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pos;
    logic [7:0]       last_seq;
    logic [7:0]       flags;
  } bstat_t;

endpackage

// File: rtl/crf_front.sv
module crf_front import crf_pkg::*; (
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_word,
  input  logic  q_full,
  output logic  q_push,
  output item_t q_item
);

  logic known;

  always_comb begin
    in_ready      = !q_full;
    known         = in_word.command <= CMD_TICK;
    q_push        = in_valid && in_ready && known;
    q_item.op     = cmd_t'(in_word.command);
    q_item.id     = in_word.element_id;
    q_item.flen   = (in_word.frame_len > MAX_FLEN) ? MAX_FLEN : in_word.frame_len;
    q_item.data   = in_word.frame_data;
    q_item.mode   = mode_t'(in_word.msg_mode);
    q_item.spos   = in_word.seq_position;
    q_item.sstart = in_word.seq_start;
    q_item.xlen   = in_word.expected_len;
  end

endmodule

// File: rtl/crf_queue.sv
module crf_queue import crf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t item_out
);

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign item_out = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/crf_back.sv
module crf_back import crf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_empty,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_word
);

  state_t st;
  state_t st_next;
  item_t  cur;

  logic [31:0]      entry_id   [ENTRIES];
  logic [ENTRIES-1:0] entry_used;
  cfg_t             entry_cfg  [ENTRIES];
  logic [ENTRIES-1:0] wsel;
  bstat_t           bstat      [2*ENTRIES];
  logic [2*ENTRIES-1:0] locked;
  logic [31:0]      stamp      [2*ENTRIES];
  logic [7:0]       mem        [MEM_DEPTH];
  logic [7:0]       rdata;
  logic [31:0]      tick_count;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_ok;
  logic [IDX_W-1:0] free_idx;
  logic             lk_hit;
  logic [IDX_W-1:0] lk_idx;
  logic             lk_free;
  logic [IDX_W-1:0] lk_fidx;

  bstat_t           ws;
  logic [BUF_W-1:0] wbuf;
  logic [3:0]       bi;
  logic [LEN_W-1:0] wpos;
  logic             chk;
  logic             m0;
  out_t             res;
  out_t             res_exec;
  logic             more;
  logic [BUF_W-1:0] rbuf;
  logic [LEN_W-1:0] p;
  logic [LEN_W-1:0] dlen;

  cfg_t             cfg_cur;
  logic [BUF_W-1:0] wb_cur;
  logic [BUF_W-1:0] rb_cur;
  bstat_t           s_w;
  bstat_t           s_r;
  bstat_t           fs;
  logic             f_loop;
  logic             f_chk;
  logic [3:0]       f_i0;
  logic [7:0]       cseq;
  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [11:0]      nl;
  logic             iso_first;
  logic             iso_cons;
  logic             frame_go;
  logic             dump_rd;
  logic             wr_go;
  bstat_t           ws_fin;
  logic             fin;
  logic             slot_free;
  logic             res_load;
  logic             mem_we;
  logic [ADDR_W-1:0] raddr;

  always_comb begin
    lk_hit  = 1'b0;
    lk_idx  = '0;
    lk_free = 1'b0;
    lk_fidx = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (entry_used[e] && entry_id[e] == cur.id) begin
        lk_hit = 1'b1;
        lk_idx = IDX_W'(e);
      end
      if (!entry_used[e]) begin
        lk_free = 1'b1;
        lk_fidx = IDX_W'(e);
      end
    end
  end

  always_comb begin
    cfg_cur   = entry_cfg[hit_idx];
    wb_cur    = {hit_idx, wsel[hit_idx]};
    rb_cur    = {hit_idx, !wsel[hit_idx]};
    s_w       = bstat[wb_cur];
    s_r       = bstat[rb_cur];
    fs        = s_w;
    f_loop    = 1'b0;
    f_chk     = 1'b0;
    f_i0      = 4'd0;
    cseq      = cur.data[{cfg_cur.spos, 3'b000} +: 8];
    b0        = cur.data[7:0];
    b1        = cur.data[15:8];
    nl        = {b0[3:0], b1};
    iso_first = b0[7:4] == ISO_FF;
    iso_cons  = (b0[7:4] == ISO_CF) &&
                (({1'b0, b0} == {1'b0, s_w.last_seq} + 9'd1) ||
                 (s_w.last_seq == ISO_CF_TOP && b0 == ISO_CF_START));
    unique case (cfg_cur.mode)
      MODE_SINGLE: begin
        if (s_w.len == LEN_W'(cur.flen)) begin
          f_loop = 1'b1;
          f_chk  = 1'b1;
        end
      end
      MODE_CUSTOM: begin
        if (cseq == cfg_cur.sstart || {1'b0, cseq} == {1'b0, s_w.last_seq} + 9'd1) begin
          if (cseq == cfg_cur.sstart) begin
            fs.valid = 1'b0;
            fs.pos   = '0;
          end
          fs.last_seq = cseq;
          f_loop      = 1'b1;
          f_chk       = 1'b1;
          f_i0        = 4'd1;
        end else begin
          fs.last_seq = '0;
        end
      end
      MODE_ISOTP: begin
        if (iso_first || iso_cons) begin
          if (iso_first) begin
            fs.valid = 1'b0;
            fs.pos   = '0;
            if (12'(s_w.len) != nl) begin
              fs.store = nl <= 12'(BUF_BYTES);
              if (nl <= 12'(BUF_BYTES)) begin
                fs.len = LEN_W'(nl);
              end
            end
          end
          if (fs.store) begin
            f_loop      = 1'b1;
            f_chk       = 1'b1;
            f_i0        = iso_first ? 4'd2 : 4'd1;
            fs.last_seq = iso_first ? ISO_CF_START : b0;
          end else begin
            fs.len = '0;
          end
        end else begin
          fs.last_seq = '0;
        end
      end
      MODE_IGNORE: begin
      end
    endcase
    frame_go = hit && cfg_cur.mode != MODE_IGNORE;
    dump_rd  = hit && s_r.valid && s_r.len != '0;
  end

  always_comb begin
    res_exec      = '0;
    res_exec.last = 1'b1;
    unique case (cur.op)
      CMD_ADD: begin
        if (hit) begin
          res_exec.status = RS_EXISTS;
        end else if (!free_ok || cur.xlen > LEN_W'(BUF_BYTES)) begin
          res_exec.status = RS_NO_ROOM;
        end
      end
      CMD_LOCK: begin
        if (!hit) begin
          res_exec.status = RS_NO_ID;
        end
      end
      CMD_DUMP: begin
        if (!hit) begin
          res_exec.status = RS_NO_ID;
        end else if (!s_r.valid) begin
          res_exec.status = RS_INVALID;
        end else begin
          res_exec.time_stamp = stamp[rb_cur];
          res_exec.flags      = s_r.flags;
          res_exec.msg_length = s_r.len;
          res_exec.last       = s_r.len == '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_go  = (bi < cur.flen) && (m0 || wpos < ws.len);
    ws_fin = ws;
    if (!m0) begin
      ws_fin.pos = wpos;
    end
    fin = chk && (m0 || wpos >= ws.len);
    if (fin) begin
      ws_fin.valid    = 1'b1;
      ws_fin.flags    = ws.flags | FLAG_NEW;
      ws_fin.last_seq = '0;
    end
    slot_free = !out_valid || out_ready;
    raddr     = {rbuf, p[POS_W-1:0]};
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (!q_empty) st_next = ST_LOOK;
      ST_LOOK: st_next = ST_EXEC;
      ST_EXEC: begin
        unique case (cur.op)
          CMD_FRAME: st_next = frame_go ? (f_loop ? ST_WR : ST_FIN) : ST_IDLE;
          CMD_TICK:  st_next = ST_IDLE;
          CMD_DUMP:  st_next = dump_rd ? ST_RA : ST_EMIT;
          default:   st_next = ST_EMIT;
        endcase
      end
      ST_WR:   if (!wr_go) st_next = ST_FIN;
      ST_FIN:  st_next = ST_IDLE;
      ST_RA:   st_next = ST_RB;
      ST_RB:   st_next = (p[2:0] == 3'd7) ? ST_EMIT : ST_RA;
      ST_EMIT: if (slot_free) st_next = more ? ST_RA : ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = st == ST_IDLE && !q_empty;
    res_load = st == ST_EMIT && slot_free;
    mem_we   = st == ST_WR && wr_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{wbuf, wpos[POS_W-1:0]}] <= cur.data[{bi[2:0], 3'b000} +: 8];
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_used <= '0;
      tick_count <= '0;
    end else begin
      if (st == ST_EXEC) begin
        unique case (cur.op)
          CMD_CLEAR: entry_used <= '0;
          CMD_ADD: begin
            if (!hit && free_ok && cur.xlen <= LEN_W'(BUF_BYTES)) begin
              entry_used[free_idx] <= 1'b1;
            end
          end
          CMD_TICK: tick_count <= tick_count + 32'd1;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      ST_IDLE: begin
        if (!q_empty) begin
          cur <= q_item;
        end
      end
      ST_LOOK: begin
        hit      <= lk_hit;
        hit_idx  <= lk_idx;
        free_ok  <= lk_free;
        free_idx <= lk_fidx;
      end
      ST_EXEC: begin
        res  <= res_exec;
        more <= 1'b0;
        unique case (cur.op)
          CMD_ADD: begin
            if (!hit && free_ok && cur.xlen <= LEN_W'(BUF_BYTES)) begin
              entry_id[free_idx]  <= cur.id;
              entry_cfg[free_idx] <= '{mode: cur.mode, spos: cur.spos, sstart: cur.sstart};
              wsel[free_idx]      <= 1'b0;
              for (int j = 0; j < 2; j++) begin
                bstat[{free_idx, 1'(j)}] <= '{valid: 1'b0, store: cur.xlen != '0,
                                              len: cur.xlen, pos: '0,
                                              last_seq: '0, flags: '0};
                locked[{free_idx, 1'(j)}] <= 1'b0;
              end
            end
          end
          CMD_FRAME: begin
            ws   <= fs;
            wbuf <= wb_cur;
            bi   <= f_i0;
            wpos <= (cfg_cur.mode == MODE_SINGLE) ? '0 : fs.pos;
            chk  <= f_chk;
            m0   <= cfg_cur.mode == MODE_SINGLE;
          end
          CMD_LOCK: begin
            if (hit) begin
              locked[rb_cur] <= 1'b1;
            end
          end
          CMD_DUMP: begin
            if (hit) begin
              locked[rb_cur] <= 1'b0;
              if (s_r.valid) begin
                bstat[rb_cur].flags <= s_r.flags & ~FLAG_NEW;
                rbuf                <= rb_cur;
                dlen                <= s_r.len;
                p                   <= '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_WR: begin
        if (wr_go) begin
          bi   <= bi + 4'd1;
          wpos <= wpos + LEN_W'(1);
        end
      end
      ST_FIN: begin
        bstat[wbuf] <= ws_fin;
        if (fin) begin
          stamp[wbuf] <= tick_count;
          if (!locked[{wbuf[BUF_W-1:1], !wbuf[0]}]) begin
            wsel[wbuf[BUF_W-1:1]] <= !wbuf[0];
          end
        end
      end
      ST_RB: begin
        res.data_word[{p[2:0], 3'b000} +: 8] <= (p < dlen) ? rdata : 8'd0;
        p <= p + LEN_W'(1);
        if (p[2:0] == 3'd7) begin
          res.last <= (p >> 3) == ((dlen - LEN_W'(1)) >> 3);
          more     <= (p >> 3) != ((dlen - LEN_W'(1)) >> 3);
        end
      end
      default: begin
      end
    endcase
  end

  a_used_only_exec: assert property (@(posedge clk) disable iff (rst)
    st != ST_EXEC |=> $stable(entry_used))
    else $error("entry table changed outside command execution");

  a_tick_only_exec: assert property (@(posedge clk) disable iff (rst)
    st != ST_EXEC |=> $stable(tick_count))
    else $error("tick count changed outside a tick command");

  a_write_only_frame: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> cur.op == CMD_FRAME && wpos < LEN_W'(BUF_BYTES))
    else $error("buffer write outside a frame or past the buffer end");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !$past(res_load))
    else $error("result loaded over a word still waiting");

endmodule

// File: rtl/can_frame_reassembly_double_buffer.sv
// A clear, add or lock word passes through lookup and execute states and then emits one result word;
// a tick or a frame gives no result word, and a frame whose checks pass writes its bytes one at a time.
// A dump of a valid buffer packs its bytes eight to a result word, each waiting for a free output slot,
// as buffer memory is read a byte at a time through one port.
// A two-entry queue lets a new word be accepted while the previous one is still at work.
// Synchronous reset clears the entry table, tick count, queue and output stage; buffers are set up on add.
module can_frame_reassembly_double_buffer import crf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_word,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_word
);

  logic  q_full;
  logic  q_push;
  item_t q_in;
  logic  q_pop;
  logic  q_empty;
  item_t q_out;

  crf_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  crf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .item_out (q_out)
  );

  crf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
